### rtl/rcfq_pkg.sv
// Shared types and codes for the CAN receive filter and frame queue.
package rcfq_pkg;

   localparam logic [1:0] FUNC_SET    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_RX     = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ALREADY  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_RXERR    = 3'd4;
   localparam logic [2:0] ST_FILTERED = 3'd5;
   localparam logic [2:0] ST_QUEUED   = 3'd6;
   localparam logic [2:0] ST_EMPTY    = 3'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] filter_id;
      logic [31:0] filter_mask;
      logic        rx_read_ok;
      logic        rx_extended;
      logic        rx_remote;
      logic [31:0] rx_id_bytes;
      logic [3:0]  rx_dlc;
      logic [63:0] rx_payload;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  filter_slot;
      logic [31:0] frame_id;
      logic [3:0]  frame_len;
      logic [63:0] frame_payload;
      logic [4:0]  queued_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      FOP_SET,
      FOP_REMOVE,
      FOP_MATCH
   } filt_op_type;

   // Completion report of the filter table
   typedef struct packed {
      logic       done;
      logic       accept;
      logic [2:0] status;
      logic [2:0] slot;
   } filt_res_type;

   typedef struct packed {
      logic [31:0] id;
      logic [3:0]  len;
      logic [63:0] payload;
   } ring_entry_type;

endpackage

### rtl/rcfq_filter_table.sv
// Acceptance filter table: id/mask memory, valid bits and a one-slot-per-cycle scan.
module rcfq_filter_table import rcfq_pkg::*; #(
   parameter int FILTER_SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  filt_op_type  op,
   input  logic [31:0]  key_id,
   input  logic [31:0]  key_mask,
   output filt_res_type res
);

   localparam int IDX_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_SLOTS - 1);

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   state_type              state_ff;
   filt_op_type            op_ff;
   logic [31:0]            key_ff;
   logic [31:0]            mask_ff;
   logic [IDX_W-1:0]       cnt_ff;
   logic                   issue_ff;
   logic                   pend_ff;
   logic [IDX_W-1:0]       pend_idx_ff;
   logic [FILTER_SLOTS-1:0] valid_ff;
   filt_res_type           res_ff;

   logic [63:0]            mem [FILTER_SLOTS];
   logic [63:0]            rd_data_ff;

   filt_op_type            op_cur;
   logic [31:0]            key_cur;
   logic [31:0]            mask_cur;
   logic [31:0]            entry_id;
   logic [31:0]            entry_mask;
   logic                   cmp_hit;
   logic                   hit;
   logic                   any_valid;
   logic                   any_free;
   logic [IDX_W-1:0]       free_idx;
   logic                   finish;
   logic                   found;
   logic                   wr_en;
   filt_res_type           res_in;

   assign op_cur   = (state_ff == S_IDLE) ? op : op_ff;
   assign key_cur  = (state_ff == S_IDLE) ? key_id : key_ff;
   assign mask_cur = (state_ff == S_IDLE) ? key_mask : mask_ff;

   assign entry_id   = rd_data_ff[63:32];
   assign entry_mask = rd_data_ff[31:0];

   always_comb begin
      if (op_ff == FOP_MATCH) begin
         cmp_hit = (entry_mask & entry_id) == (entry_mask & key_ff);
      end else begin
         cmp_hit = (entry_id == key_ff);
      end
   end

   assign hit       = pend_ff && valid_ff[pend_idx_ff] && cmp_hit;
   assign any_valid = |valid_ff;
   assign any_free  = ~&valid_ff;

   // Lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = FILTER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // An empty table needs no scan
   assign finish = (state_ff == S_IDLE) ? (start && !any_valid)
                                        : (pend_ff && (hit || pend_idx_ff == LAST_IDX));
   assign found  = (state_ff == S_SCAN) && hit;
   assign wr_en  = finish && (op_cur == FOP_SET) && !found && any_free;

   always_comb begin
      res_in        = '0;
      res_in.done   = finish;
      case (op_cur)
         FOP_SET: begin
            if (found) begin
               res_in.status = ST_ALREADY;
               res_in.slot   = 3'(pend_idx_ff);
            end else if (any_free) begin
               res_in.status = ST_OK;
               res_in.slot   = 3'(free_idx);
            end else begin
               res_in.status = ST_FULL;
            end
         end
         FOP_REMOVE: begin
            if (found) begin
               res_in.status = ST_OK;
               res_in.slot   = 3'(pend_idx_ff);
            end else begin
               res_in.status = ST_NOTFOUND;
            end
         end
         FOP_MATCH: begin
            res_in.accept = found || !any_valid;
         end
         default: begin
            res_in.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[cnt_ff];
      if (wr_en) begin
         mem[free_idx] <= {key_cur, mask_cur};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
         valid_ff <= '0;
         res_ff   <= '0;
      end else begin
         res_ff <= res_in;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= op;
                  key_ff   <= key_id;
                  mask_ff  <= key_mask;
                  cnt_ff   <= '0;
                  pend_ff  <= 1'b0;
                  issue_ff <= any_valid;
                  if (any_valid) begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               pend_idx_ff <= cnt_ff;
               if (issue_ff && (cnt_ff != LAST_IDX)) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (finish) begin
                  state_ff <= S_IDLE;
                  pend_ff  <= 1'b0;
                  issue_ff <= 1'b0;
               end else begin
                  pend_ff  <= issue_ff;
                  issue_ff <= issue_ff && (cnt_ff != LAST_IDX);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (wr_en) begin
            valid_ff[free_idx] <= 1'b1;
         end
         if (finish && (op_cur == FOP_REMOVE) && found) begin
            valid_ff[pend_idx_ff] <= 1'b0;
         end
      end
   end

   assign res = res_ff;

endmodule

### rtl/rcfq_frame_ring.sv
// Ring of received frames in one memory with write/read pointers and a fill count.
module rcfq_frame_ring import rcfq_pkg::*; #(
   parameter int RING_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  ring_entry_type                  push_data,
   input  logic                            pop,
   output ring_entry_type                  pop_data,
   output logic [$clog2(RING_DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

   ring_entry_type   mem [RING_DEPTH];
   ring_entry_type   rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign pop_data = rd_data_ff;
   assign count    = count_ff;

endmodule

### rtl/can_rx_filter_and_frame_queue.sv
// CAN receive path: id/mask acceptance filter table feeding a queue of received frames.
// Result strobe comes in the cycle after accept for an rx error or an empty read; a pop
// goes via T_POP and any filter request via the filter result register, where a non-empty
// table is scanned one slot per cycle up to a hit; busy stays high until the strobe cycle.
// One item at a time; the next item may be accepted in the strobe cycle. Reset clears
// filter valid bits, ring pointers and counts; memories need no clearing pass.
module can_rx_filter_and_frame_queue import rcfq_pkg::*; #(
   parameter int FILTER_SLOTS = 8,
   parameter int RING_DEPTH   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   typedef enum logic [1:0] {T_IDLE, T_FILT, T_POP} state_type;

   state_type      state_ff;
   req_item_type   req_ff;
   logic [31:0]    id_ff;
   rsp_item_type   rsp_ff;
   logic           strobe_ff;

   state_type      state_in;
   req_item_type   req_in;
   logic [31:0]    id_in;
   rsp_item_type   rsp_in;
   logic           strobe_in;

   logic           accept;
   logic [31:0]    rx_id;
   logic [CNT_W-1:0] ring_count;
   logic           ring_full;
   logic           ring_empty;
   logic [4:0]     count5;
   logic [4:0]     count_inc5;
   logic           filt_start;
   filt_op_type    filt_op;
   logic [31:0]    filt_key;
   filt_res_type   filt_res;
   logic           push;
   logic           pop;
   ring_entry_type push_data;
   ring_entry_type pop_data;

   assign accept = start && (state_ff == T_IDLE);
   assign busy   = (state_ff != T_IDLE);

   // Rebuild the identifier, RTR in bit 30, EFF in bit 31
   always_comb begin
      if (req_item.rx_extended) begin
         rx_id = {1'b1, req_item.rx_remote, 1'b0, req_item.rx_id_bytes[31:3]};
      end else begin
         rx_id = {1'b0, req_item.rx_remote, 19'd0, req_item.rx_id_bytes[31:21]};
      end
   end

   assign ring_full  = (ring_count == CNT_W'(RING_DEPTH));
   assign ring_empty = (ring_count == '0);
   assign count5     = 5'(ring_count);
   assign count_inc5 = 5'(ring_count + 1'b1);

   always_comb begin
      filt_start = 1'b0;
      filt_op    = FOP_SET;
      filt_key   = req_item.filter_id;
      case (req_item.func)
         FUNC_SET: begin
            filt_start = accept;
         end
         FUNC_REMOVE: begin
            filt_start = accept;
            filt_op    = FOP_REMOVE;
         end
         FUNC_RX: begin
            filt_start = accept && req_item.rx_read_ok && !ring_full;
            filt_op    = FOP_MATCH;
            filt_key   = rx_id;
         end
         default: begin
            filt_start = 1'b0;
         end
      endcase
   end

   assign push = (state_ff == T_FILT) && filt_res.done && (req_ff.func == FUNC_RX) &&
                 filt_res.accept;
   assign pop  = accept && (req_item.func == FUNC_READ) && !ring_empty;

   assign push_data = {id_ff, req_ff.rx_dlc, req_ff.rx_payload};

   rcfq_filter_table #(
      .FILTER_SLOTS (FILTER_SLOTS)
   ) u_filter (
      .clock    (clock),
      .reset    (reset),
      .start    (filt_start),
      .op       (filt_op),
      .key_id   (filt_key),
      .key_mask (req_item.filter_mask),
      .res      (filt_res)
   );

   rcfq_frame_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (ring_count)
   );

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      req_in    = req_ff;
      id_in     = id_ff;
      rsp_in    = rsp_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               req_in              = req_item;
               id_in               = rx_id;
               rsp_in              = '0;
               rsp_in.queued_count = count5;
               case (req_item.func)
                  FUNC_SET, FUNC_REMOVE: begin
                     state_in = T_FILT;
                  end
                  FUNC_RX: begin
                     if (!req_item.rx_read_ok || ring_full) begin
                        rsp_in.status = ST_RXERR;
                        strobe_in     = 1'b1;
                     end else begin
                        state_in = T_FILT;
                     end
                  end
                  default: begin
                     if (ring_empty) begin
                        rsp_in.status = ST_EMPTY;
                        strobe_in     = 1'b1;
                     end else begin
                        state_in = T_POP;
                     end
                  end
               endcase
            end
         end
         T_FILT: begin
            if (filt_res.done) begin
               strobe_in = 1'b1;
               state_in  = T_IDLE;
               rsp_in    = '0;
               if (req_ff.func == FUNC_RX) begin
                  rsp_in.frame_id = id_ff;
                  if (filt_res.accept) begin
                     rsp_in.status       = ST_QUEUED;
                     rsp_in.queued_count = count_inc5;
                  end else begin
                     rsp_in.status       = ST_FILTERED;
                     rsp_in.queued_count = count5;
                  end
               end else begin
                  rsp_in.status       = filt_res.status;
                  rsp_in.filter_slot  = filt_res.slot;
                  rsp_in.queued_count = count5;
               end
            end
         end
         T_POP: begin
            // Ring count already reflects the pop
            strobe_in            = 1'b1;
            state_in             = T_IDLE;
            rsp_in.status        = ST_OK;
            rsp_in.filter_slot   = '0;
            rsp_in.frame_id      = pop_data.id;
            rsp_in.frame_len     = pop_data.len;
            rsp_in.frame_payload = pop_data.payload;
            rsp_in.queued_count  = count5;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         req_ff    <= req_in;
         id_ff     <= id_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### bench/testbench.sv
// Self-checking bench for the CAN receive filter table and frame queue.
`timescale 1ns / 1ps

module testbench;
   import rcfq_pkg::*;

   localparam int FILTER_SLOTS = 8;
   localparam int RING_DEPTH   = 16;
   localparam int ID_POOL_SIZE = 12;
   localparam int CYCLE_LIMIT  = 200000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   can_rx_filter_and_frame_queue #(
      .FILTER_SLOTS(FILTER_SLOTS),
      .RING_DEPTH(RING_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   // predicted filter table and frame ring
   logic [31:0]             flt_id   [FILTER_SLOTS];
   logic [31:0]             flt_mask [FILTER_SLOTS];
   logic [FILTER_SLOTS-1:0] flt_valid;
   int                      flt_count;
   logic [31:0]             ring_id   [RING_DEPTH];
   logic [3:0]              ring_len  [RING_DEPTH];
   logic [63:0]             ring_data [RING_DEPTH];
   int                      wr_ptr;
   int                      rd_ptr;
   int                      frame_count;

   rsp_item_type pending_rsp [$];
   logic [31:0]  id_pool [ID_POOL_SIZE];
   int           sender_idle_pct;
   int           error_count;
   int           cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   function automatic void clear_can_state();
      flt_valid   = '0;
      flt_count   = 0;
      wr_ptr      = 0;
      rd_ptr      = 0;
      frame_count = 0;
   endfunction

   // Advance the predicted state by one item and return its result.
   function automatic rsp_item_type predict_can_rx(input req_item_type rq);
      rsp_item_type rs;
      logic [31:0]  rid;
      bit           hit;
      rs = '0;
      case (rq.func)
         FUNC_SET: begin
            hit = 1'b0;
            for (int i = 0; i < FILTER_SLOTS && !hit; i++) begin
               if (flt_valid[i] && flt_id[i] == rq.filter_id) begin
                  rs.status      = ST_ALREADY;
                  rs.filter_slot = 3'(i);
                  hit            = 1'b1;
               end
            end
            for (int i = 0; i < FILTER_SLOTS && !hit; i++) begin
               if (!flt_valid[i]) begin
                  flt_id[i]      = rq.filter_id;
                  flt_mask[i]    = rq.filter_mask;
                  flt_valid[i]   = 1'b1;
                  flt_count++;
                  rs.status      = ST_OK;
                  rs.filter_slot = 3'(i);
                  hit            = 1'b1;
               end
            end
            if (!hit)
               rs.status = ST_FULL;
         end
         FUNC_REMOVE: begin
            rs.status = ST_NOTFOUND;
            hit = 1'b0;
            for (int i = 0; i < FILTER_SLOTS && !hit; i++) begin
               if (flt_valid[i] && flt_id[i] == rq.filter_id) begin
                  flt_valid[i]   = 1'b0;
                  if (flt_count > 0)
                     flt_count--;
                  rs.status      = ST_OK;
                  rs.filter_slot = 3'(i);
                  hit            = 1'b1;
               end
            end
         end
         FUNC_RX: begin
            if (!rq.rx_read_ok || frame_count >= RING_DEPTH) begin
               rs.status = ST_RXERR;
            end else begin
               if (rq.rx_extended)
                  rid = {3'b000, rq.rx_id_bytes[31:3]};
               else
                  rid = {21'd0, rq.rx_id_bytes[31:21]};
               if (rq.rx_remote)
                  rid[30] = 1'b1;
               if (rq.rx_extended)
                  rid[31] = 1'b1;
               hit = (flt_count == 0);
               for (int i = 0; i < FILTER_SLOTS && !hit; i++) begin
                  if (flt_valid[i] && (flt_mask[i] & flt_id[i]) == (flt_mask[i] & rid))
                     hit = 1'b1;
               end
               rs.frame_id = rid;
               if (hit) begin
                  ring_id[wr_ptr]   = rid;
                  ring_len[wr_ptr]  = rq.rx_dlc;
                  ring_data[wr_ptr] = rq.rx_payload;
                  wr_ptr            = (wr_ptr + 1) % RING_DEPTH;
                  frame_count++;
                  rs.status         = ST_QUEUED;
               end else begin
                  rs.status = ST_FILTERED;
               end
            end
         end
         default: begin
            if (frame_count == 0) begin
               rs.status = ST_EMPTY;
            end else begin
               rs.frame_id      = ring_id[rd_ptr];
               rs.frame_len     = ring_len[rd_ptr];
               rs.frame_payload = ring_data[rd_ptr];
               rd_ptr           = (rd_ptr + 1) % RING_DEPTH;
               frame_count--;
               rs.status        = ST_OK;
            end
         end
      endcase
      rs.queued_count = 5'(frame_count);
      return rs;
   endfunction

   // Present one item, hold it until accepted, then log its expected result.
   task automatic send_item(input req_item_type item);
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(predict_can_rx(item));
   endtask

   // Hold off the next item until every outstanding result has come back.
   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   function automatic req_item_type filter_req(input logic [1:0] func,
                                               input logic [31:0] fid,
                                               input logic [31:0] fmask);
      req_item_type rq;
      rq             = '0;
      rq.func        = func;
      rq.filter_id   = fid;
      rq.filter_mask = fmask;
      return rq;
   endfunction

   function automatic req_item_type frame_req(input logic ok, input logic ext,
                                              input logic rtr, input logic [31:0] id_bytes,
                                              input logic [3:0] dlc,
                                              input logic [63:0] payload);
      req_item_type rq;
      rq             = '0;
      rq.func        = FUNC_RX;
      rq.rx_read_ok  = ok;
      rq.rx_extended = ext;
      rq.rx_remote   = rtr;
      rq.rx_id_bytes = id_bytes;
      rq.rx_dlc      = dlc;
      rq.rx_payload  = payload;
      return rq;
   endfunction

   function automatic req_item_type random_item();
      req_item_type rq;
      rq.func        = 2'($urandom);
      rq.filter_id   = $urandom;
      rq.filter_mask = $urandom;
      rq.rx_read_ok  = 1'($urandom);
      rq.rx_extended = 1'($urandom);
      rq.rx_remote   = 1'($urandom);
      rq.rx_id_bytes = $urandom;
      rq.rx_dlc      = 4'($urandom);
      rq.rx_payload  = {$urandom, $urandom};
      return rq;
   endfunction

   // Build id bytes that rebuild to the given identifier; unused bits random.
   function automatic req_item_type frame_for_id(input logic [31:0] cid);
      logic [31:0] id_bytes;
      if (cid[31])
         id_bytes = {cid[28:0], 3'($urandom)};
      else
         id_bytes = {cid[10:0], 21'($urandom)};
      return frame_req($urandom_range(19) != 0, cid[31], cid[30], id_bytes,
                       4'($urandom), {$urandom, $urandom});
   endfunction

   function automatic void refresh_id_pool();
      logic ext;
      logic rtr;
      for (int i = 0; i < ID_POOL_SIZE; i++) begin
         ext = 1'($urandom);
         rtr = 1'($urandom);
         if (ext)
            id_pool[i] = {1'b1, rtr, 1'b0, 29'($urandom)};
         else
            id_pool[i] = {1'b0, rtr, 19'd0, 11'($urandom)};
      end
   endfunction

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1, 2:    return 32'hC000_07FF;
         3:       return 32'hFFFF_FF00;
         4, 5:    return $urandom;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic test_directed_frames();
      send_item(filter_req(FUNC_READ, '0, '0));
      send_item(frame_req(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(frame_req(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 4'h0, 64'h0));
      send_item(frame_req(1'b0, 1'b1, 1'b1, 32'hA5A5_5A5A, 4'h8, 64'h1));
      send_item(frame_req(1'b1, 1'b0, 1'b0, 32'h0, 4'h8, 64'h0123_4567_89AB_CDEF));
      repeat (4) send_item(filter_req(FUNC_READ, '0, '0));
   endtask

   task automatic test_directed_filters();
      send_item(filter_req(FUNC_REMOVE, 32'h0, 32'h0));
      send_item(filter_req(FUNC_SET, 32'h0, 32'hFFFF_FFFF));
      send_item(filter_req(FUNC_SET, 32'h0, 32'h0));
      for (int k = 1; k < FILTER_SLOTS; k++)
         send_item(filter_req(FUNC_SET, 32'h8000_0000 | (k * 32'h0012_3457), 32'hFFFF_FFFF));
      send_item(filter_req(FUNC_SET, 32'h0000_1234, 32'hFFFF_FFFF));
      // id zero hits the slot holding filter id zero
      send_item(frame_req(1'b1, 1'b0, 1'b0, 32'h0, 4'h3, 64'hDEAD_BEEF));
      send_item(frame_req(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 4'h5, 64'h55));
      send_item(filter_req(FUNC_REMOVE, 32'h8000_0000 | (3 * 32'h0012_3457), 32'h0));
      // a zero mask accepts every frame
      send_item(filter_req(FUNC_SET, 32'hFFFF_FFFF, 32'h0));
      send_item(frame_req(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 4'h5, 64'h55));
      repeat (2) send_item(filter_req(FUNC_READ, '0, '0));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int item_goal);
      int sent;
      int pick;
      int burst;
      sender_idle_pct = idle_pct;
      refresh_id_pool();
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_item(random_item());
            sent++;
         end else if (pick < 32) begin
            if ($urandom_range(1))
               send_item(filter_req(FUNC_SET, id_pool[$urandom_range(ID_POOL_SIZE-1)],
                                    pick_mask()));
            else
               send_item(filter_req(FUNC_REMOVE, id_pool[$urandom_range(ID_POOL_SIZE-1)],
                                    $urandom));
            sent++;
         end else if (pick < 35) begin
            // drop every filter so frames pass unfiltered
            for (int i = 0; i < FILTER_SLOTS; i++) begin
               if (flt_valid[i]) begin
                  send_item(filter_req(FUNC_REMOVE, flt_id[i], 32'h0));
                  sent++;
               end
            end
         end else if (pick < 70) begin
            burst = $urandom_range(14, 1);
            repeat (burst) begin
               if ($urandom_range(4) != 0)
                  send_item(frame_for_id(id_pool[$urandom_range(ID_POOL_SIZE-1)]));
               else
                  send_item(frame_req($urandom_range(19) != 0, 1'($urandom), 1'($urandom),
                                      $urandom, 4'($urandom), {$urandom, $urandom}));
               sent++;
            end
         end else begin
            burst = $urandom_range(14, 1);
            repeat (burst) send_item(filter_req(FUNC_READ, $urandom, $urandom));
            sent += burst;
         end
         if ($urandom_range(39) == 0)
            wait_for_results();
      end
      wait_for_results();
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result strobe with no item outstanding");
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", rsp_item.status, want.status);
            check_field("filter_slot", rsp_item.filter_slot, want.filter_slot);
            check_field("frame_id", rsp_item.frame_id, want.frame_id);
            check_field("frame_len", rsp_item.frame_len, want.frame_len);
            check_field("frame_payload", rsp_item.frame_payload, want.frame_payload);
            check_field("queued_count", rsp_item.queued_count, want.queued_count);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("can_rx_filter_and_frame_queue test failed");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_item        = '0;
      error_count     = 0;
      sender_idle_pct = 0;
      clear_can_state();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_directed_filters();
      wait_for_results();
      test_random_traffic(17, 230);
      test_random_traffic(61, 230);
      test_random_traffic(0, 230);

      wait_for_results();
      repeat (FILTER_SLOTS + 4) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));
      if (error_count == 0)
         $display("can_rx_filter_and_frame_queue test passed");
      else
         $display("can_rx_filter_and_frame_queue test failed");
      $finish;
   end

endmodule

### can_rx_filter_and_frame_queue.f
rtl/rcfq_pkg.sv
rtl/rcfq_filter_table.sv
rtl/rcfq_frame_ring.sv
rtl/can_rx_filter_and_frame_queue.sv
bench/testbench.sv
